// ----- rtl/eth_rx_af_pkg.sv -----
// Shared types and constants for the receive address filter with ring head.
// No dependencies; imported by every module of the block.
package eth_rx_af_pkg;

  localparam int ADDR_W    = 48;
  localparam int STATUS_W  = 32;
  localparam int LEN_W     = 14;
  localparam int LEN_LSB   = 16;
  localparam int SLOT_W    = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 3;

  // Defaults for the top-level parameters
  localparam int RING_SLOTS_DEF  = 32;
  localparam int MCAST_SLOTS_DEF = 4;

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_OWN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MCNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MCAST0 = 3'd3;

  localparam logic [ADDR_W-1:0] OWN_RESET   = '0;
  localparam logic [ADDR_W-1:0] BCAST_RESET = '1;

  typedef struct packed {
    logic [ADDR_W-1:0]   dest_address;
    logic [STATUS_W-1:0] desc_status;
    logic [LEN_W-1:0]    buffer_len;
  } in_t;

  typedef struct packed {
    logic              accepted;
    logic [LEN_W-1:0]  frame_len;
    logic [SLOT_W-1:0] slot;
    logic              end_of_ring;
  } out_t;

  // Fixed station addresses from the register bank
  typedef struct packed {
    logic [ADDR_W-1:0] own_address;
    logic [ADDR_W-1:0] broadcast_address;
  } addr_cfg_t;

  // Ring position handed out with each descriptor
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              last;
  } ring_t;

endpackage

// ----- rtl/eth_rx_af_regs.sv -----
// Configuration register bank: station addresses and multicast table.
// Depends on eth_rx_af_pkg.
module eth_rx_af_regs #(
  parameter int MCAST_SLOTS = eth_rx_af_pkg::MCAST_SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [eth_rx_af_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eth_rx_af_pkg::ADDR_W-1:0]     cfg_wdata,
  output eth_rx_af_pkg::addr_cfg_t             addr_cfg,
  output logic [eth_rx_af_pkg::ADDR_W-1:0]     mcast_tbl [MCAST_SLOTS],
  output logic [MCAST_SLOTS-1:0]               mcast_en
);
  import eth_rx_af_pkg::*;

  addr_cfg_t         addr_cfg_r;
  logic [CNT_W-1:0]  mcast_count_r;
  logic [ADDR_W-1:0] mcast_tbl_r [MCAST_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_cfg_r.own_address       <= OWN_RESET;
      addr_cfg_r.broadcast_address <= BCAST_RESET;
      mcast_count_r                <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN:   addr_cfg_r.own_address       <= cfg_wdata;
        CFG_BCAST: addr_cfg_r.broadcast_address <= cfg_wdata;
        CFG_MCNT:  mcast_count_r                <= cfg_wdata[CNT_W-1:0];
        default: ;  // table entries below, others ignored
      endcase
    end
  end

  for (genvar k = 0; k < MCAST_SLOTS; k++) begin : g_tbl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mcast_tbl_r[k] <= '0;
      end else if (cfg_we && cfg_index == CFG_MCAST0 + CFG_IDX_W'(k)) begin
        mcast_tbl_r[k] <= cfg_wdata;
      end
    end
    // count above the table size saturates naturally
    assign mcast_en[k]  = (CNT_W'(k) < mcast_count_r);
    assign mcast_tbl[k] = mcast_tbl_r[k];
  end

  assign addr_cfg = addr_cfg_r;

endmodule

// ----- rtl/eth_rx_af_match.sv -----
// Destination compare and length cap, pure combinational.
// Depends on eth_rx_af_pkg.
module eth_rx_af_match #(
  parameter int MCAST_SLOTS = eth_rx_af_pkg::MCAST_SLOTS_DEF
) (
  input  eth_rx_af_pkg::in_t                item,
  input  eth_rx_af_pkg::addr_cfg_t          addr_cfg,
  input  logic [eth_rx_af_pkg::ADDR_W-1:0]  mcast_tbl [MCAST_SLOTS],
  input  logic [MCAST_SLOTS-1:0]            mcast_en,
  output logic                              accepted,
  output logic [eth_rx_af_pkg::LEN_W-1:0]   frame_len
);
  import eth_rx_af_pkg::*;

  logic [MCAST_SLOTS-1:0] mcast_hit;
  logic [LEN_W-1:0]       len_raw;
  logic [LEN_W-1:0]       len_cap;

  for (genvar k = 0; k < MCAST_SLOTS; k++) begin : g_cmp
    assign mcast_hit[k] = mcast_en[k] && (item.dest_address == mcast_tbl[k]);
  end

  assign accepted = (item.dest_address == addr_cfg.own_address) ||
                    (item.dest_address == addr_cfg.broadcast_address) ||
                    (|mcast_hit);

  assign len_raw   = item.desc_status[LEN_LSB +: LEN_W];
  assign len_cap   = (len_raw > item.buffer_len) ? item.buffer_len : len_raw;
  assign frame_len = accepted ? len_cap : '0;

endmodule

// ----- rtl/eth_rx_af_ring.sv -----
// Descriptor ring head counter, wraps at RING_SLOTS.
// Depends on eth_rx_af_pkg.
module eth_rx_af_ring #(
  parameter int RING_SLOTS = eth_rx_af_pkg::RING_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  output eth_rx_af_pkg::ring_t ring
);
  import eth_rx_af_pkg::*;

  localparam int HEAD_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(RING_SLOTS - 1);

  logic [HEAD_W-1:0] head_r;
  logic [HEAD_W-1:0] head_nxt;
  logic              last;

  assign last     = (head_r == HEAD_LAST);
  assign head_nxt = last ? '0 : head_r + HEAD_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else if (advance) begin
      head_r <= head_nxt;
    end
  end

  // slot field carries the low bits of the head
  assign ring.slot = SLOT_W'(head_r);
  assign ring.last = last;

endmodule

// ----- rtl/eth_rx_address_filter_ring_top.sv -----
// Top level of the receive destination-address filter with ring head.
// Depends on eth_rx_af_pkg, eth_rx_af_regs, eth_rx_af_match, eth_rx_af_ring.
//
// One receive descriptor beat in, one result beat out, one beat per clock
// sustained while out_ready is high. A beat is registered at the input
// together with its ring slot, matched against own, broadcast and the
// enabled multicast entries in the following cycle, and registered at the
// output: out_valid rises when the beat moves from the input stage into the
// output register. The input stage keeps taking beats while a result waits,
// and stalls only when both stages hold data and out_ready is low. Every
// descriptor advances the ring head (wrapping at RING_SLOTS) whether or not
// the frame is accepted; dropped frames report frame_len 0. Registers are
// written through cfg_we/cfg_index/cfg_wdata, by the user only while no beats
// are in flight (the block does not enforce this); an unknown index is ignored
// and a multicast count above the table size enables the whole table.
module eth_rx_address_filter_ring_top #(
  parameter int RING_SLOTS  = eth_rx_af_pkg::RING_SLOTS_DEF,
  parameter int MCAST_SLOTS = eth_rx_af_pkg::MCAST_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // descriptor beats
  input  logic                                in_valid,
  output logic                                in_ready,
  input  eth_rx_af_pkg::in_t                  in_data,
  // result beats
  output logic                                out_valid,
  input  logic                                out_ready,
  output eth_rx_af_pkg::out_t                 out_data,
  // register writes
  input  logic                                cfg_we,
  input  logic [eth_rx_af_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eth_rx_af_pkg::ADDR_W-1:0]    cfg_wdata
);
  import eth_rx_af_pkg::*;

  addr_cfg_t              addr_cfg;
  logic [ADDR_W-1:0]      mcast_tbl [MCAST_SLOTS];
  logic [MCAST_SLOTS-1:0] mcast_en;
  ring_t                  ring;

  // input stage
  logic  s1_valid_r;
  in_t   s1_data_r;
  ring_t s1_ring_r;
  // output stage
  logic  out_valid_r;
  logic  out_valid_nxt;
  out_t  out_data_r;
  out_t  out_data_nxt;

  logic       in_fire;
  logic       s1_fire;
  logic       hit;
  logic [LEN_W-1:0] len;

  eth_rx_af_regs #(.MCAST_SLOTS(MCAST_SLOTS)) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .addr_cfg  (addr_cfg),
    .mcast_tbl (mcast_tbl),
    .mcast_en  (mcast_en)
  );

  eth_rx_af_ring #(.RING_SLOTS(RING_SLOTS)) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_fire),
    .ring    (ring)
  );

  eth_rx_af_match #(.MCAST_SLOTS(MCAST_SLOTS)) u_match (
    .item      (s1_data_r),
    .addr_cfg  (addr_cfg),
    .mcast_tbl (mcast_tbl),
    .mcast_en  (mcast_en),
    .accepted  (hit),
    .frame_len (len)
  );

  // output register free or draining this cycle
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
      s1_ring_r <= ring;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    out_data_nxt.accepted    = hit;
    out_data_nxt.frame_len   = len;
    out_data_nxt.slot        = s1_ring_r.slot;
    out_data_nxt.end_of_ring = s1_ring_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a beat leaving the input stage always lands in the output register
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("input stage beat lost");

  // dropped frames never report a length
  a_drop_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.accepted |-> out_data_r.frame_len == '0)
    else $error("dropped frame with nonzero length");

  // an empty input stage never back-pressures
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled while empty");

  // both stages full and output stalled: input must stall
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken with both stages full");

endmodule
